### hdl/assert_macros.svh
// ------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the colormap interpolator checks.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define CMCI_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define CMCI_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/cmci_pkg.sv
// ------------------------------------------------------------------------
// cmci_pkg
// Types, constants and field helpers of the colormap cubic interpolator.
// ------------------------------------------------------------------------
`default_nettype none

package cmci_pkg;

  // Control point configuration.
  localparam int NUM_POINTS    = 5;
  localparam int REG_COUNT     = 5;
  localparam int USED_POINTS   = (NUM_POINTS > REG_COUNT) ? REG_COUNT :
                                 ((NUM_POINTS < 2) ? 2 : NUM_POINTS);
  localparam int NUM_INTERVALS = USED_POINTS - 1;
  localparam int REG_WIDTH     = 40;

  // Configuration port geometry: one 64-bit register every 8 bytes.
  localparam int DATA_WIDTH    = 64;
  localparam int ADDR_WIDTH    = 6;
  localparam int IDX_LSB       = 3;
  localparam int IDX_WIDTH     = ADDR_WIDTH - IDX_LSB;

  // Datapath widths.
  localparam int SAMPLE_WIDTH  = 24;
  localparam int POS_WIDTH     = 16;
  localparam int CHAN_WIDTH    = 8;
  localparam int T_WIDTH       = POS_WIDTH + 1;
  localparam int W_WIDTH       = 49;
  localparam int W_SPLIT       = 24;
  localparam int PP_WIDTH      = 33;
  localparam int PROD_WIDTH    = 57;
  localparam int ACC_WIDTH     = 58;

  // Long division of the span fraction: quotient bits retired per stage.
  localparam int DIV_STEPS_PER_STAGE = 3;
  localparam int DIV_STAGES = (T_WIDTH + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;

  localparam logic [POS_WIDTH-1:0] ONE_Q15 = 16'd32768;

  // Fallback color when no interval holds the sample.
  localparam logic [CHAN_WIDTH-1:0] FALLBACK_RED   = 8'd252;
  localparam logic [CHAN_WIDTH-1:0] FALLBACK_GREEN = 8'd3;
  localparam logic [CHAN_WIDTH-1:0] FALLBACK_BLUE  = 8'd253;

  // Channel order inside a packed color.
  localparam int CH_BLUE  = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_RED   = 2;
  localparam int NUM_CH   = 3;

  localparam logic [REG_WIDTH-1:0] RESET_POINTS [REG_COUNT] = '{
    40'd16711680, 40'd137455730432, 40'd274877972224,
    40'd412316860671, 40'd549772525823
  };

  typedef logic [NUM_CH-1:0][CHAN_WIDTH-1:0] rgb_t;

  // What the interval search hands to the rest of the pipeline.
  typedef struct packed {
    logic no_match;
    logic zero_span;
    rgb_t c0;
    rgb_t c1;
  } span_t;

  function automatic logic [POS_WIDTH-1:0] pt_pos(input logic [REG_WIDTH-1:0] r);
    pt_pos = r[REG_WIDTH-1:REG_WIDTH-POS_WIDTH];
  endfunction

  function automatic rgb_t pt_color(input logic [REG_WIDTH-1:0] r);
    pt_color = r[NUM_CH*CHAN_WIDTH-1:0];
  endfunction

endpackage

`default_nettype wire

### hdl/colormap_cubic_interpolator_top.sv
// ------------------------------------------------------------------------
// colormap_cubic_interpolator_top
// Maps a signed Q8.15 sample to an 8-bit RGB color by a cubic blend of
// the two end colors of the first control interval that holds it.
// ------------------------------------------------------------------------
// Usage:
//   Input channel: sample_valid / sample_ready carry one sample per transfer.
//   Output channel: color_valid / color_ready carry red, green, blue and
//   no_interval, one result per sample, in order.
//   Configuration: an APB-style port holds the five control points at byte
//   addresses 0, 8, 16, 24 and 32; write them only while the pipeline is
//   empty. pready is always high and reads return the stored point.
//   Throughput: one sample per clock while no waiting result stalls the
//   pipeline. The depth is set mostly by the 17-bit long division for
//   the span fraction (six stages of up to three bits) followed by the
//   weight multiply chain and the per-channel blend.
//   Reset: rst clears every stage valid bit and restores the default
//   rainbow points (red, yellow, green, blue, magenta).
//   Stall: while color_ready is low and a result waits, the whole pipeline
//   holds and sample_ready drops; nothing is lost or repeated.
// ------------------------------------------------------------------------
`default_nettype none

module colormap_cubic_interpolator_top (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [cmci_pkg::ADDR_WIDTH-1:0]        paddr,
  input  logic [cmci_pkg::DATA_WIDTH-1:0]        pwdata,
  output logic [cmci_pkg::DATA_WIDTH-1:0]        prdata,
  output logic                                   pready,
  input  logic                                   sample_valid,
  output logic                                   sample_ready,
  input  logic signed [cmci_pkg::SAMPLE_WIDTH-1:0] sample,
  output logic                                   color_valid,
  input  logic                                   color_ready,
  output logic [cmci_pkg::CHAN_WIDTH-1:0]        red,
  output logic [cmci_pkg::CHAN_WIDTH-1:0]        green,
  output logic [cmci_pkg::CHAN_WIDTH-1:0]        blue,
  output logic                                   no_interval
);
  import cmci_pkg::*;

  // ----------------------------------------------------------------------
  // Configuration registers
  // ----------------------------------------------------------------------
  logic [REG_WIDTH-1:0] point [REG_COUNT];
  logic [IDX_WIDTH-1:0] cfg_idx;
  logic                 cfg_write;

  assign cfg_idx   = paddr[ADDR_WIDTH-1:IDX_LSB];
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  // Control points are written on the access cycle of a write transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        point[i] <= RESET_POINTS[i];
      end
    end else if (cfg_write && (cfg_idx < IDX_WIDTH'(REG_COUNT))) begin
      point[cfg_idx] <= pwdata[REG_WIDTH-1:0];
    end
  end

  // Read data for the addressed point, zero beyond the last one.
  always_comb begin
    prdata = '0;
    if (cfg_idx < IDX_WIDTH'(REG_COUNT)) begin
      prdata = {{(DATA_WIDTH-REG_WIDTH){1'b0}}, point[cfg_idx]};
    end
  end

  // ----------------------------------------------------------------------
  // Pipeline flow: every stage moves when the output slot is free.
  // ----------------------------------------------------------------------
  logic adv;

  assign adv          = !color_valid || color_ready;
  assign sample_ready = adv;

  // ----------------------------------------------------------------------
  // Stage 1: clamp the sample and test every interval.
  // ----------------------------------------------------------------------
  logic [POS_WIDTH-1:0]     v_clamp;
  logic [NUM_INTERVALS-1:0] hit_next;
  logic                     s1_valid;
  logic [POS_WIDTH-1:0]     s1_v;
  logic [NUM_INTERVALS-1:0] s1_hit;

  always_comb begin
    if (sample[SAMPLE_WIDTH-1]) begin
      v_clamp = '0;
    end else if (sample[SAMPLE_WIDTH-2:0] > (SAMPLE_WIDTH-1)'(ONE_Q15)) begin
      v_clamp = ONE_Q15;
    end else begin
      v_clamp = sample[POS_WIDTH-1:0];
    end
    for (int i = 0; i < NUM_INTERVALS; i++) begin
      hit_next[i] = (v_clamp >= pt_pos(point[i])) && (v_clamp <= pt_pos(point[i+1]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_v   <= v_clamp;
      s1_hit <= hit_next;
    end
  end

  // ----------------------------------------------------------------------
  // Stage 2: pick the first matching interval and form the fraction
  // operands. Its registers are the entry of the divider chain.
  // ----------------------------------------------------------------------
  logic [POS_WIDTH:0]   div_x   [DIV_STAGES+1];
  logic [T_WIDTH-1:0]   div_q   [DIV_STAGES+1];
  logic [POS_WIDTH-1:0] div_den [DIV_STAGES+1];
  span_t                div_pl  [DIV_STAGES+1];
  logic                 div_valid [DIV_STAGES+1];

  logic [POS_WIDTH-1:0] sel_p0;
  logic [POS_WIDTH-1:0] sel_p1;
  rgb_t                 sel_c0;
  rgb_t                 sel_c1;
  logic                 seen;
  logic                 first;
  span_t                span_next;

  always_comb begin
    sel_p0 = '0;
    sel_p1 = '0;
    sel_c0 = '0;
    sel_c1 = '0;
    seen   = 1'b0;
    first  = 1'b0;
    // One-hot priority select: the lowest matching interval wins.
    for (int i = 0; i < NUM_INTERVALS; i++) begin
      first = s1_hit[i] && !seen;
      seen  = seen || s1_hit[i];
      sel_p0 = sel_p0 | ({POS_WIDTH{first}} & pt_pos(point[i]));
      sel_p1 = sel_p1 | ({POS_WIDTH{first}} & pt_pos(point[i+1]));
      sel_c0 = sel_c0 | ({(NUM_CH*CHAN_WIDTH){first}} & pt_color(point[i]));
      sel_c1 = sel_c1 | ({(NUM_CH*CHAN_WIDTH){first}} & pt_color(point[i+1]));
    end
    span_next.no_match  = !seen;
    span_next.zero_span = (sel_p1 == sel_p0);
    span_next.c0        = sel_c0;
    span_next.c1        = sel_c1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_valid[0] <= 1'b0;
    end else if (adv) begin
      div_valid[0] <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div_x[0]   <= {1'b0, s1_v - sel_p0};
      div_q[0]   <= '0;
      div_den[0] <= sel_p1 - sel_p0;
      div_pl[0]  <= span_next;
    end
  end

  // ----------------------------------------------------------------------
  // Divider stages: restoring long division of (v - p0) * 2^16 by
  // (p1 - p0). The numerator never exceeds the span, so the quotient
  // fits in 17 bits and the partial remainder stays below the span.
  // ----------------------------------------------------------------------
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    logic [POS_WIDTH:0] x_next;
    logic [T_WIDTH-1:0] q_next;

    always_comb begin
      logic [POS_WIDTH:0] r;
      logic               b;
      x_next = div_x[s];
      q_next = div_q[s];
      for (int k = 0; k < DIV_STEPS_PER_STAGE; k++) begin
        if (s * DIV_STEPS_PER_STAGE + k < T_WIDTH) begin
          b = (x_next >= {1'b0, div_den[s]});
          r = b ? (x_next - {1'b0, div_den[s]}) : x_next;
          q_next = {q_next[T_WIDTH-2:0], b};
          x_next = {r[POS_WIDTH-1:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        div_valid[s+1] <= 1'b0;
      end else if (adv) begin
        div_valid[s+1] <= div_valid[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        div_x[s+1]   <= x_next;
        div_q[s+1]   <= q_next;
        div_den[s+1] <= div_den[s];
        div_pl[s+1]  <= div_pl[s];
      end
    end
  end

  // ----------------------------------------------------------------------
  // Weight stage 1: t^2 and t*(1-t).
  // ----------------------------------------------------------------------
  logic [T_WIDTH-1:0]   t_sel;
  logic [T_WIDTH-1:0]   u_sel;
  logic [2*POS_WIDTH:0] t_wide;
  logic [2*POS_WIDTH:0] u_wide;
  logic                 m1_valid;
  logic [T_WIDTH-1:0]   m1_t;
  logic [2*POS_WIDTH:0] m1_t2;
  logic [2*POS_WIDTH:0] m1_tu;
  span_t                m1_pl;

  always_comb begin
    // An interval of zero width yields the start color.
    t_sel  = div_pl[DIV_STAGES].zero_span ? '0 : div_q[DIV_STAGES];
    u_sel  = {1'b1, {POS_WIDTH{1'b0}}} - t_sel;
    t_wide = {{POS_WIDTH{1'b0}}, t_sel};
    u_wide = {{POS_WIDTH{1'b0}}, u_sel};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else if (adv) begin
      m1_valid <= div_valid[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_t  <= t_sel;
      m1_t2 <= t_wide * t_wide;
      m1_tu <= t_wide * u_wide;
      m1_pl <= div_pl[DIV_STAGES];
    end
  end

  // ----------------------------------------------------------------------
  // Weight stage 2: t^3 and 3*t*(1-t).
  // ----------------------------------------------------------------------
  logic                   m2_valid;
  logic [W_WIDTH-1:0]     m2_t3;
  logic [2*POS_WIDTH+1:0] m2_tu3;
  span_t                  m2_pl;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_valid <= 1'b0;
    end else if (adv) begin
      m2_valid <= m1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_t3  <= {{(W_WIDTH-2*POS_WIDTH-1){1'b0}}, m1_t2} *
                {{(W_WIDTH-T_WIDTH){1'b0}}, m1_t};
      m2_tu3 <= {1'b0, m1_tu} + {m1_tu, 1'b0};
      m2_pl  <= m1_pl;
    end
  end

  // ----------------------------------------------------------------------
  // Weight stage 3: w1 = t^3 + 3*t*(1-t)/2 in unsigned Q1.48, and the color steps.
  // ----------------------------------------------------------------------
  logic                                m3_valid;
  logic [W_WIDTH-1:0]                  m3_w1;
  logic signed [CHAN_WIDTH:0]          m3_d [NUM_CH];
  rgb_t                                m3_c0;
  logic                                m3_no_match;

  always_ff @(posedge clk) begin
    if (rst) begin
      m3_valid <= 1'b0;
    end else if (adv) begin
      m3_valid <= m2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m3_w1       <= m2_t3 + {m2_tu3, {(POS_WIDTH-1){1'b0}}};
      m3_c0       <= m2_pl.c0;
      m3_no_match <= m2_pl.no_match;
      for (int k = 0; k < NUM_CH; k++) begin
        m3_d[k] <= $signed({1'b0, m2_pl.c1[k]}) - $signed({1'b0, m2_pl.c0[k]});
      end
    end
  end

  // ----------------------------------------------------------------------
  // Blend stage 1: w1 * (c1 - c0) as two partial products per channel.
  // ----------------------------------------------------------------------
  logic                        m4_valid;
  logic signed [PP_WIDTH-1:0]  m4_ph [NUM_CH];
  logic signed [PP_WIDTH-1:0]  m4_pl [NUM_CH];
  rgb_t                        m4_c0;
  logic                        m4_no_match;

  always_ff @(posedge clk) begin
    if (rst) begin
      m4_valid <= 1'b0;
    end else if (adv) begin
      m4_valid <= m3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m4_c0       <= m3_c0;
      m4_no_match <= m3_no_match;
      for (int k = 0; k < NUM_CH; k++) begin
        m4_ph[k] <= $signed({1'b0, m3_w1[W_WIDTH-1:W_SPLIT]}) * m3_d[k];
        m4_pl[k] <= $signed({1'b0, m3_w1[W_SPLIT-1:0]}) * m3_d[k];
      end
    end
  end

  // ----------------------------------------------------------------------
  // Blend stage 2: join the partial products.
  // ----------------------------------------------------------------------
  logic                         m5_valid;
  logic signed [PROD_WIDTH-1:0] m5_prod [NUM_CH];
  rgb_t                         m5_c0;
  logic                         m5_no_match;

  always_ff @(posedge clk) begin
    if (rst) begin
      m5_valid <= 1'b0;
    end else if (adv) begin
      m5_valid <= m4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m5_c0       <= m4_c0;
      m5_no_match <= m4_no_match;
      for (int k = 0; k < NUM_CH; k++) begin
        m5_prod[k] <= $signed({m4_ph[k], {W_SPLIT{1'b0}}}) +
                      $signed({{(PROD_WIDTH-PP_WIDTH){m4_pl[k][PP_WIDTH-1]}}, m4_pl[k]});
      end
    end
  end

  // ----------------------------------------------------------------------
  // Output stage: c0 * 2^48 + one half + step product, rounded to 8 bits,
  // or the fallback purple when no interval matched.
  // ----------------------------------------------------------------------
  logic signed [ACC_WIDTH-1:0] acc [NUM_CH];
  rgb_t                        rgb_next;
  rgb_t                        rgb_out;

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      acc[k] = $signed({2'b00, m5_c0[k], 1'b1, {(W_WIDTH-2){1'b0}}}) +
               $signed({m5_prod[k][PROD_WIDTH-1], m5_prod[k]});
      rgb_next[k] = acc[k][W_WIDTH+CHAN_WIDTH-2:W_WIDTH-1];
    end
    if (m5_no_match) begin
      rgb_next[CH_RED]   = FALLBACK_RED;
      rgb_next[CH_GREEN] = FALLBACK_GREEN;
      rgb_next[CH_BLUE]  = FALLBACK_BLUE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      color_valid <= 1'b0;
    end else if (adv) begin
      color_valid <= m5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rgb_out     <= rgb_next;
      no_interval <= m5_no_match;
    end
  end

  assign red   = rgb_out[CH_RED];
  assign green = rgb_out[CH_GREEN];
  assign blue  = rgb_out[CH_BLUE];

endmodule

`default_nettype wire

### hdl/cmci_checker.sv
// ------------------------------------------------------------------------
// cmci_checker
// Port-level checks of the colormap interpolator, bound to the top level.
// ------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cmci_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             pready,
  input logic                             color_valid,
  input logic                             color_ready,
  input logic [cmci_pkg::CHAN_WIDTH-1:0]  red,
  input logic [cmci_pkg::CHAN_WIDTH-1:0]  green,
  input logic [cmci_pkg::CHAN_WIDTH-1:0]  blue,
  input logic                             no_interval
);
  import cmci_pkg::*;

  logic                      stalled;
  logic [NUM_CH*CHAN_WIDTH:0] payload;
  logic                      purple;

  // A result is offered but the receiver holds it off.
  assign stalled = color_valid && !color_ready;
  assign payload = {red, green, blue, no_interval};
  assign purple  = (red == FALLBACK_RED) && (green == FALLBACK_GREEN) &&
                   (blue == FALLBACK_BLUE);

  // A stalled result stays offered.
  `CMCI_ASSERT(a_valid_holds, clk, rst, stalled |=> color_valid, "color_valid dropped early")

  // A stalled result keeps its payload.
  `CMCI_ASSERT(a_payload_holds, clk, rst, stalled |=> $stable(payload), "result changed in stall")

  // An unmatched sample always comes out as the fallback purple.
  `CMCI_ASSERT(a_fallback_color, clk, rst, color_valid && no_interval |-> purple, "fallback wrong")

  // Reset empties the output slot.
  `CMCI_ASSERT_ALWAYS(a_reset_empties, clk, rst |=> !color_valid, "result offered after reset")

  // The configuration port never inserts wait states.
  `CMCI_ASSERT_ALWAYS(a_pready_high, clk, pready, "pready low")

endmodule

bind colormap_cubic_interpolator_top cmci_checker u_cmci_checker (.*);

`default_nettype wire
